// ----- design/length_framed_bit_receiver_defines.svh -----
// Assertion helpers for the framed bit receiver.
`ifndef LENGTH_FRAMED_BIT_RECEIVER_DEFINES_SVH
`define LENGTH_FRAMED_BIT_RECEIVER_DEFINES_SVH

// Clocked implication, disabled in reset.
`define LFBR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Clocked implication with the consequent checked in the next cycle.
`define LFBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lfbr_pkg.sv -----
package lfbr_pkg;

  localparam int HEADER_DIGITS_DEF = 10;
  localparam int SENDER_BITS_DEF   = 22;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int BITCNT_W = 3;
  localparam int DIGIT_W  = 4;
  localparam int ACC_W    = 34;
  localparam int LEFT_W   = 33;
  localparam int PHASE_W  = 2;
  localparam int STATUS_W = 2;

  localparam logic [ADDR_W-1:0] REG_MAX_LENGTH = '0;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TERM   = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

endpackage

// ----- design/length_framed_bit_receiver.sv -----
// Length-framed bit receiver. Each request carries one bit and its sender id; bits are packed
// LSB first into bytes. The first bit after idle locks the session to its sender. The first
// HEADER_DIGITS bytes are ASCII decimal digits giving the payload length (MSB digit first);
// a non-digit ends the session with status 1, a length above max_length (register at byte
// address 0, reset all ones) with status 2. Then length+1 payload bytes are delivered, the last
// flagged by message_done and required to be zero (status 3 otherwise). Header bits are always
// acknowledged; payload bits only from the locked sender. Every request gives exactly one
// result. Throughput is one request per cycle while result_stall does not hold the result
// register: an input register feeds the combinational state update (one 34-bit
// multiply-by-ten add and one compare against max_length), which loads the result register.
`include "length_framed_bit_receiver_defines.svh"

module length_framed_bit_receiver #(
  parameter int HEADER_DIGITS = lfbr_pkg::HEADER_DIGITS_DEF,
  parameter int SENDER_BITS   = lfbr_pkg::SENDER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfbr_pkg::ADDR_W-1:0]   paddr,
  input  logic [lfbr_pkg::DATA_W-1:0]   pwdata,
  output logic [lfbr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [SENDER_BITS-1:0]        sender_id,
  input  logic                          bit_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          ack,
  output logic                          byte_valid,
  output logic [lfbr_pkg::BYTE_W-1:0]   data_byte,
  output logic                          message_done,
  output logic [lfbr_pkg::STATUS_W-1:0] status,
  output logic [SENDER_BITS-1:0]        locked_sender
);
  import lfbr_pkg::*;

  logic [DATA_W-1:0]      max_length;
  logic                   s1_valid;
  logic [SENDER_BITS-1:0] s1_sid;
  logic                   s1_bit;
  logic                   advance;

  logic [PHASE_W-1:0]     phase, phase_next;
  logic [BITCNT_W-1:0]    bit_count, bit_count_next;
  logic [BYTE_W-1:0]      shift_byte, shift_byte_next;
  logic [DIGIT_W-1:0]     digit_count, digit_count_next;
  logic [ACC_W-1:0]       length_accum, length_accum_next;
  logic [LEFT_W-1:0]      bytes_left, bytes_left_next;
  logic [SENDER_BITS-1:0] sender_lock, sender_lock_next;

  logic                   eff_idle;
  logic [BITCNT_W-1:0]    cur_bit_count;
  logic [BYTE_W-1:0]      cur_shift;
  logic [DIGIT_W-1:0]     cur_digit;
  logic [ACC_W-1:0]       cur_accum;
  logic [LEFT_W-1:0]      cur_left;
  logic                   sid_match;
  logic [BYTE_W-1:0]      shift_new;
  logic                   byte_done;
  logic                   is_digit;
  logic [ACC_W-1:0]       accum_new;
  logic [DIGIT_W-1:0]     digit_new;

  logic                   ack_next, byte_valid_next, done_next;
  logic [BYTE_W-1:0]      data_byte_next;
  logic [STATUS_W-1:0]    status_next;

  // Config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_LENGTH) ? max_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= '1;
    end else if (psel && penable && pwrite && paddr == REG_MAX_LENGTH) begin
      max_length <= pwdata;
    end
  end

  // Handshake
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_sid <= sender_id;
      s1_bit <= bit_value;
    end
  end

  // State update
  assign eff_idle      = (phase != PH_HEADER) && (phase != PH_PAYLOAD);
  assign cur_bit_count = eff_idle ? '0 : bit_count;
  assign cur_shift     = eff_idle ? '0 : shift_byte;
  assign cur_digit     = eff_idle ? '0 : digit_count;
  assign cur_accum     = eff_idle ? '0 : length_accum;
  assign cur_left      = eff_idle ? '0 : bytes_left;
  assign sender_lock_next = eff_idle ? s1_sid : sender_lock;
  assign sid_match     = (s1_sid == sender_lock_next);

  assign shift_new = cur_shift | (BYTE_W'(s1_bit) << cur_bit_count);
  assign byte_done = (cur_bit_count == BITCNT_W'(BYTE_W - 1));
  assign is_digit  = (shift_new >= CHAR_ZERO) && (shift_new <= CHAR_NINE);
  assign accum_new = ACC_W'({cur_accum, 3'b000}) + ACC_W'({cur_accum, 1'b0})
                     + ACC_W'(shift_new[3:0]);
  assign digit_new = cur_digit + DIGIT_W'(1);

  always_comb begin
    phase_next        = eff_idle ? PH_HEADER : phase;
    bit_count_next    = cur_bit_count;
    shift_byte_next   = cur_shift;
    digit_count_next  = cur_digit;
    length_accum_next = cur_accum;
    bytes_left_next   = cur_left;
    ack_next          = 1'b0;
    byte_valid_next   = 1'b0;
    data_byte_next    = '0;
    done_next         = 1'b0;
    status_next       = ST_OK;
    case (phase_next)
      PH_HEADER: begin
        ack_next = 1'b1;
        if (sid_match) begin
          bit_count_next  = cur_bit_count + BITCNT_W'(1);
          shift_byte_next = byte_done ? '0 : shift_new;
          if (byte_done) begin
            if (!is_digit) begin
              status_next = ST_BAD_DIGIT;
              phase_next  = PH_IDLE;
            end else begin
              length_accum_next = accum_new;
              digit_count_next  = digit_new;
              if (digit_new >= DIGIT_W'(HEADER_DIGITS)) begin
                if (accum_new > ACC_W'(max_length)) begin
                  status_next = ST_TOO_LARGE;
                  phase_next  = PH_IDLE;
                end else begin
                  // remaining count kept as length; last byte seen when it reads zero
                  bytes_left_next  = accum_new[LEFT_W-1:0];
                  digit_count_next = '0;
                  phase_next       = PH_PAYLOAD;
                end
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (sid_match) begin
          ack_next        = 1'b1;
          bit_count_next  = cur_bit_count + BITCNT_W'(1);
          shift_byte_next = byte_done ? '0 : shift_new;
          if (byte_done) begin
            byte_valid_next = 1'b1;
            data_byte_next  = shift_new;
            bytes_left_next = cur_left - LEFT_W'(1);
            if (cur_left == '0) begin
              done_next   = 1'b1;
              status_next = (shift_new != '0) ? ST_NO_TERM : ST_OK;
              phase_next  = PH_IDLE;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      sender_lock <= '0;
    end else if (s1_valid && advance) begin
      phase       <= phase_next;
      sender_lock <= sender_lock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      digit_count  <= digit_count_next;
      length_accum <= length_accum_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      ack           <= ack_next;
      byte_valid    <= byte_valid_next;
      data_byte     <= data_byte_next;
      message_done  <= done_next;
      status        <= status_next;
      locked_sender <= sender_lock_next;
    end
  end

  `LFBR_ASSERT_IMPL(a_done_has_byte, result_valid && message_done, byte_valid, "done without byte")
  `LFBR_ASSERT_IMPL(a_byte_status, result_valid && byte_valid,
                    status == ST_OK || status == ST_NO_TERM, "header error on payload byte")
  `LFBR_ASSERT_IMPL(a_stall_cause, item_stall, s1_valid && result_valid && result_stall,
                    "input stalled without a blocked result")
  `LFBR_ASSERT_NEXT(a_hdr_error_idle, s1_valid && advance && phase_next == PH_IDLE,
                    phase == PH_IDLE, "session not closed")

endmodule

// ----- dv/length_framed_bit_receiver_test.sv -----
module length_framed_bit_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfbr_pkg::*;

  localparam int SB         = SENDER_BITS_DEF;
  localparam int HDR_DIGITS = HEADER_DIGITS_DEF;
  localparam int QUIET_MAX  = 3000;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic [PHASE_W-1:0]  stage;
    logic [BITCNT_W-1:0] nbits;
    logic [BYTE_W-1:0]   shreg;
    logic [DIGIT_W-1:0]  ndigits;
    logic [ACC_W-1:0]    length;
    logic [LEFT_W-1:0]   left;
    logic [SB-1:0]       owner;
    logic [DATA_W-1:0]   max_len;
  } rx_state_t;

  typedef struct packed {
    logic                ack;
    logic                byte_valid;
    logic [BYTE_W-1:0]   data_byte;
    logic                message_done;
    logic [STATUS_W-1:0] status;
    logic [SB-1:0]       locked_sender;
  } rx_result_t;

  typedef struct packed {
    logic [SB-1:0] sid;
    logic          value;
  } bit_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [SB-1:0] sender_id = '0;
  logic bit_value = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic ack;
  logic byte_valid;
  logic [BYTE_W-1:0] data_byte;
  logic message_done;
  logic [STATUS_W-1:0] status;
  logic [SB-1:0] locked_sender;

  rx_state_t  gen_st;
  rx_state_t  chk_st;
  bit_req_t   pending[$];
  rx_result_t expected_q[$];
  logic       in_fire = 1'b0;
  int         errors = 0;
  int         quiet = 0;
  int         queued = 0;
  int         cut_left = -1;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_ask = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         stretch_left = 0;
  int         stall_pct = 0;

  length_framed_bit_receiver u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .sender_id    (sender_id),
    .bit_value    (bit_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ack          (ack),
    .byte_valid   (byte_valid),
    .data_byte    (data_byte),
    .message_done (message_done),
    .status       (status),
    .locked_sender(locked_sender)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // session model, shared by the generator and the checker (separate state copies)
  function automatic void clear_session(inout rx_state_t s);
    s.stage   = PH_IDLE;
    s.nbits   = '0;
    s.shreg   = '0;
    s.ndigits = '0;
    s.length  = '0;
    s.left    = '0;
  endfunction

  function automatic logic shift_in(inout rx_state_t s, input logic b);
    s.shreg = s.shreg | (BYTE_W'(b) << s.nbits);
    s.nbits = s.nbits + 1'b1;
    return s.nbits == '0;
  endfunction

  function automatic rx_result_t absorb_bit(inout rx_state_t s, input logic [SB-1:0] sid,
                                            input logic b);
    rx_result_t r;
    logic [BYTE_W-1:0] ch;
    r = '0;
    if (s.stage != PH_HEADER && s.stage != PH_PAYLOAD) begin
      clear_session(s);
      s.stage = PH_HEADER;
      s.owner = sid;
    end
    r.locked_sender = s.owner;
    if (s.stage == PH_HEADER) begin
      r.ack = 1'b1;
      if (sid == s.owner && shift_in(s, b)) begin
        ch = s.shreg;
        s.shreg = '0;
        if (ch < CHAR_ZERO || ch > CHAR_NINE) begin
          r.status = ST_BAD_DIGIT;
          clear_session(s);
        end else begin
          s.length  = s.length * 10 + (ch - CHAR_ZERO);
          s.ndigits = s.ndigits + 1'b1;
          if (s.ndigits >= HDR_DIGITS) begin
            if (s.length > ACC_W'(s.max_len)) begin
              r.status = ST_TOO_LARGE;
              clear_session(s);
            end else begin
              s.left    = LEFT_W'(s.length + 1);
              s.stage   = PH_PAYLOAD;
              s.ndigits = '0;
            end
          end
        end
      end
    end else if (sid == s.owner) begin
      r.ack = 1'b1;
      if (shift_in(s, b)) begin
        r.data_byte  = s.shreg;
        r.byte_valid = 1'b1;
        s.shreg      = '0;
        s.left       = s.left - 1'b1;
        if (s.left == '0) begin
          r.message_done = 1'b1;
          if (r.data_byte != '0) r.status = ST_NO_TERM;
          clear_session(s);
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [SB-1:0] pick_sender();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [SB-1:0] stranger(logic [SB-1:0] sid);
    logic [SB-1:0] o;
    if ($urandom_range(0, 1)) begin
      o = sid ^ (SB'(1) << $urandom_range(0, SB - 1));
    end else begin
      o = SB'($urandom);
      if (o == sid) o = ~sid;
    end
    return o;
  endfunction

  // stimulus generation, tracked against gen_st so sessions can be closed cleanly
  task automatic push_bit(logic [SB-1:0] sid, logic b);
    bit_req_t r;
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    r.sid   = sid;
    r.value = b;
    pending.push_back(r);
    queued++;
    void'(absorb_bit(gen_st, sid, b));
  endtask

  task automatic push_byte(logic [SB-1:0] sid, logic [BYTE_W-1:0] val, int noise, bit first);
    for (int i = 0; i < BYTE_W; i++) begin
      if (!(first && i == 0) && $urandom_range(0, 99) < noise)
        push_bit(stranger(sid), 1'($urandom_range(0, 1)));
      push_bit(sid, val[i]);
    end
  endtask

  task automatic send_header(logic [SB-1:0] sid, longint unsigned value, int noise);
    longint unsigned scale;
    scale = 1;
    repeat (HDR_DIGITS - 1) scale = scale * 10;
    for (int k = 0; k < HDR_DIGITS; k++) begin
      push_byte(sid, CHAR_ZERO + BYTE_W'((value / scale) % 10), noise, k == 0);
      scale = scale / 10;
    end
  endtask

  task automatic send_frame(logic [SB-1:0] sid, longint unsigned len, logic [BYTE_W-1:0] term,
                            int noise);
    logic [BYTE_W-1:0] pb;
    send_header(sid, len, noise);
    for (longint unsigned j = 0; j < len; j++) begin
      case ($urandom_range(0, 3))
        0: pb = 8'h00;
        1: pb = 8'hFF;
        default: pb = BYTE_W'($urandom);
      endcase
      push_byte(sid, pb, noise, 1'b0);
    end
    push_byte(sid, term, noise, 1'b0);
  endtask

  task automatic send_bad_header(logic [SB-1:0] sid, int pos, logic [BYTE_W-1:0] bad,
                                 int noise);
    for (int k = 0; k < pos; k++)
      push_byte(sid, CHAR_ZERO + BYTE_W'($urandom_range(0, 9)), noise, k == 0);
    push_byte(sid, bad, noise, pos == 0);
  endtask

  // close whatever session is open: ones end a header on a non-digit
  task automatic settle();
    while (gen_st.stage != PH_IDLE) begin
      if (gen_st.stage == PH_HEADER) push_bit(gen_st.owner, 1'b1);
      else push_bit(gen_st.owner, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_traffic(int budget);
    int stop;
    int pick;
    int noise;
    logic [SB-1:0] sid;
    logic [BYTE_W-1:0] bad;
    longint unsigned cap;
    longint unsigned over;
    stop = queued + budget;
    while (queued < stop) begin
      sid   = pick_sender();
      noise = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 30) : 0;
      pick  = $urandom_range(0, 99);
      cap   = (gen_st.max_len < 8) ? gen_st.max_len : 8;
      if (pick < 60) begin
        send_frame(sid, $urandom_range(0, int'(cap)),
                   ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom_range(1, 255)) : 8'h00,
                   noise);
      end else if (pick < 75) begin
        bad = BYTE_W'($urandom);
        if (bad >= CHAR_ZERO && bad <= CHAR_NINE) bad = bad ^ 8'h80;
        send_bad_header(sid, $urandom_range(0, HDR_DIGITS - 1), bad, noise);
      end else if (pick < 85) begin
        over = longint'(gen_st.max_len) + 1 + $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0 || over > 64'd9999999999) over = 64'd9999999999;
        send_header(sid, over, noise);
      end else if (pick < 93) begin
        cut_left = $urandom_range(1, 120);
        send_frame(sid, $urandom_range(0, int'(cap)), 8'h00, noise);
        cut_left = -1;
      end else begin
        repeat ($urandom_range(1, 24)) push_bit(pick_sender(), 1'($urandom_range(0, 1)));
      end
      settle();
    end
  endtask

  task automatic program_max_length(logic [DATA_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_LENGTH;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chk_st.max_len = v;
    gen_st.max_len = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("max_length readback", v, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending.size() != 0 || item_valid || expected_q.size() != 0);
  endtask

  // request driver: bursts with random gaps
  always @(negedge clk) begin : drv
    bit_req_t nxt;
    if (!rst && (!item_valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        sender_id  <= nxt.sid;
        bit_value  <= nxt.value;
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0
                       : $urandom_range(1, ($urandom_range(0, 5) == 0) ? 15 : 4);
        end else begin
          burst_left--;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin : rcv
    logic hold_now;
    if (hold_left != 0) begin
      hold_left--;
      hold_now = 1'b1;
    end else if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD - 1;
      hold_now  = 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(10, 150);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      stretch_left--;
      hold_now = ($urandom_range(0, 99) < stall_pct);
    end
    result_stall <= hold_now;
  end

  always @(posedge clk) begin : mon
    rx_result_t want;
    if (rst) begin
      in_fire <= 1'b0;
      quiet = 0;
    end else begin
      in_fire <= item_valid && !item_stall;
      if (item_valid && !item_stall)
        expected_q.push_back(absorb_bit(chk_st, sender_id, bit_value));
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 30)
            $display("%0t: unexpected result, expected none, actual ack=%0b byte=%0h st=%0d",
                     $time, ack, data_byte, status);
        end else begin
          want = expected_q.pop_front();
          check_field("ack", want.ack, ack);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("data_byte", want.data_byte, data_byte);
          check_field("message_done", want.message_done, message_done);
          check_field("status", want.status, status);
          check_field("locked_sender", want.locked_sender, locked_sender);
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_MAX) begin
          $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stim
    logic [DATA_W-1:0] setting;
    logic [SB-1:0] sid;
    chk_st = '0;
    chk_st.max_len = '1;
    gen_st = chk_st;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full range length limit
    program_max_length(32'hFFFF_FFFF);
    send_frame('0, 0, 8'h00, 0);
    send_frame('1, 2, 8'h00, 0);
    send_frame(SB'(22'h2AAAAA), 1, 8'hA5, 0);
    send_frame(SB'(22'h155555), 0, 8'hFF, 0);
    send_bad_header('1, 0, 8'h2F, 0);
    send_bad_header('0, HDR_DIGITS - 1, 8'h3A, 0);
    send_bad_header(SB'(22'h12345), 4, 8'hFF, 0);
    send_bad_header(SB'(22'h3F0F0F), 2, 8'h00, 0);
    send_header('1, 64'd9999999999, 0);
    sid = pick_sender();
    send_frame(sid, 3, 8'h00, 40);
    settle();
    drain();

    // zero limit: only empty messages get through
    program_max_length(32'h0);
    send_frame(SB'(22'h0000FF), 0, 8'h00, 0);
    send_header(SB'(22'h0000FF), 1, 0);
    settle();
    drain();

    // limit boundary
    program_max_length(32'd5);
    send_frame(SB'(22'h3FFF00), 5, 8'h00, 10);
    send_header(SB'(22'h3FFF00), 6, 0);
    settle();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: setting = $urandom;
        1: setting = 32'hFFFF_FFFF;
        2: setting = $urandom_range(1, 8);
        3: setting = 32'h0;
        default: setting = $urandom_range(0, 20);
      endcase
      program_max_length(setting);
      random_traffic(10);
      if (p == 1) hold_ask++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results still expected, actual none", $time, expected_q.size());
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/lfbr_pkg.sv
design/length_framed_bit_receiver.sv
dv/length_framed_bit_receiver_test.sv
